[design/hufd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and codes for the Huffman tree loader and decoder.
// ----------------------------------------------------------------------------
package hufd_pkg;

    localparam int NODE_SLOTS_DEF  = 512;
    localparam int STACK_SLOTS_DEF = 256;

    // Input opcodes
    localparam logic [1:0] OP_TOKEN = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_SYMBOL    = 2'd0;
    localparam logic [1:0] ST_COMPLETE  = 2'd1;
    localparam logic [1:0] ST_BAD_TREE  = 2'd2;
    localparam logic [1:0] ST_NO_TREE   = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic       token_is_leaf;
        logic [7:0] token_symbol;
        logic       data_bit;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] decoded_symbol;
    } t_out;

endpackage

[design/hufd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/huffman_tree_load_and_decode_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode_top
// Huffman decoder: loads a code tree from preorder tokens, then decodes bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one transaction per
//   item: a tree token, a coded data bit, or a clear. Output channel
//   (o_out_valid / i_out_ready / o_out) carries status and decoded symbol.
//   Load the tree as preorder tokens first; status "tree complete" is sent
//   once no internal node is left open. Each data bit then walks one level
//   down; reaching a leaf sends its symbol and returns to the root.
//   Errors: single-leaf tree, node table or open-node stack overflow give
//   "bad tree"; data before a complete tree gives "no tree".
// Throughput and timing:
//   One transaction per cycle while the output is not stalled. A result is
//   registered in the cycle after its transaction is accepted. Each bit needs a
//   single read of the child RAMs; their address is the next current node,
//   so the data is ready by the time the following bit arrives.
// Reset and stall:
//   Synchronous active-low reset (or a clear transaction) empties the tree
//   and returns to the root; RAM contents are left as they are. If the
//   receiver stalls with a result held, input is taken only when the held
//   result leaves in the same cycle.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode_top #(
    parameter int NODE_SLOTS  = hufd_pkg::NODE_SLOTS_DEF,
    parameter int STACK_SLOTS = hufd_pkg::STACK_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  hufd_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output hufd_pkg::t_out o_out
);

    import hufd_pkg::*;

    localparam int NW  = $clog2(NODE_SLOTS);       // node index
    localparam int NCW = $clog2(NODE_SLOTS + 1);   // node count
    localparam int SW  = $clog2(STACK_SLOTS);      // stack address
    localparam int SPW = $clog2(STACK_SLOTS + 1);  // stack pointer
    localparam int CEW = 1 + 8 + NW;               // child entry: leaf, symbol, index

    // Control state
    logic           r_out_valid;
    t_out           r_out, n_out;
    logic           r_ready, n_ready;
    logic           r_error, n_error;
    logic [SPW-1:0] r_sp, n_sp;
    logic [NCW-1:0] r_nodes, n_nodes;
    logic [NW-1:0]  r_cur, n_cur;
    logic [NW-1:0]  r_top_idx, n_top_idx;   // top of open-node stack, held in flops
    logic           r_top_done, n_top_done; // left child of top already attached

    // Same-cycle write/read bypass for each RAM
    logic           r_lfwd_hit, n_lfwd_hit;
    logic           r_rfwd_hit, n_rfwd_hit;
    logic           r_sfwd_hit, n_sfwd_hit;
    logic [CEW-1:0] r_cfwd_data;
    logic [NW-1:0]  r_sfwd_data;

    logic           in_fire;
    logic           emit;

    // RAM ports
    logic           lt_we, rt_we, stk_we;
    logic [CEW-1:0] child_wdata;
    logic [CEW-1:0] lt_q, rt_q, lt_rd, rt_rd, child_sel;
    logic [SW-1:0]  stk_waddr, stk_raddr;
    logic [NW-1:0]  stk_q, stk_rd;
    logic [SPW-1:0] sp_after, sp_below;
    logic [NW-1:0]  new_idx;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign lt_rd  = r_lfwd_hit ? r_cfwd_data : lt_q;
    assign rt_rd  = r_rfwd_hit ? r_cfwd_data : rt_q;
    assign stk_rd = r_sfwd_hit ? r_sfwd_data : stk_q;

    assign new_idx     = r_nodes[NW-1:0];
    assign child_wdata = {i_in.token_is_leaf, i_in.token_symbol, new_idx};
    assign child_sel   = i_in.data_bit ? rt_rd : lt_rd;
    assign stk_waddr   = SW'(r_sp - SPW'(1));
    assign sp_below    = n_sp - SPW'(2);
    assign stk_raddr   = sp_below[SW-1:0];

    always_comb begin
        n_ready    = r_ready;
        n_error    = r_error;
        n_sp       = r_sp;
        n_nodes    = r_nodes;
        n_cur      = r_cur;
        n_top_idx  = r_top_idx;
        n_top_done = r_top_done;
        n_out      = r_out;
        emit       = 1'b0;
        lt_we      = 1'b0;
        rt_we      = 1'b0;
        stk_we     = 1'b0;
        sp_after   = r_sp;

        if (in_fire) begin
            unique case (i_in.opcode)
                OP_TOKEN: begin
                    if (!r_ready && !r_error) begin
                        priority if (r_nodes == NCW'(NODE_SLOTS)) begin
                            n_error = 1'b1;
                            emit    = 1'b1;
                            n_out   = '{status: ST_BAD_TREE, decoded_symbol: 8'd0};
                        end else if (r_nodes == '0 && i_in.token_is_leaf) begin
                            n_error = 1'b1;
                            emit    = 1'b1;
                            n_out   = '{status: ST_BAD_TREE, decoded_symbol: 8'd0};
                        end else if (r_nodes != '0 && r_sp == '0) begin
                            n_error = 1'b1;
                            emit    = 1'b1;
                            n_out   = '{status: ST_BAD_TREE, decoded_symbol: 8'd0};
                        end else if (!i_in.token_is_leaf && !(r_nodes != '0 && r_top_done)
                                     && r_sp == SPW'(STACK_SLOTS)) begin
                            n_error = 1'b1;
                            emit    = 1'b1;
                            n_out   = '{status: ST_BAD_TREE, decoded_symbol: 8'd0};
                        end else begin
                            // attach new node to the open parent on top
                            if (r_nodes != '0) begin
                                if (r_top_done) begin
                                    rt_we    = 1'b1;
                                    sp_after = r_sp - SPW'(1);
                                end else begin
                                    lt_we      = 1'b1;
                                    n_top_done = 1'b1;
                                end
                            end
                            n_nodes = r_nodes + NCW'(1);
                            if (!i_in.token_is_leaf) begin
                                // old top spills to RAM unless it was just closed
                                if (r_nodes != '0 && !r_top_done) begin
                                    stk_we = 1'b1;
                                end
                                n_top_idx  = new_idx;
                                n_top_done = 1'b0;
                                sp_after   = sp_after + SPW'(1);
                            end else if (r_top_done) begin
                                // parent closed: entry below becomes top
                                n_top_idx  = stk_rd;
                                n_top_done = 1'b1;
                            end
                            n_sp = sp_after;
                            if (sp_after == '0) begin
                                n_ready = 1'b1;
                                n_cur   = '0;
                                emit    = 1'b1;
                                n_out   = '{status: ST_COMPLETE, decoded_symbol: 8'd0};
                            end
                        end
                    end
                end
                OP_DATA: begin
                    emit = 1'b1;
                    if (!r_ready) begin
                        n_out = '{status: ST_NO_TREE, decoded_symbol: 8'd0};
                    end else if (child_sel[CEW-1]) begin
                        n_cur = '0;
                        n_out = '{status: ST_SYMBOL,
                                  decoded_symbol: child_sel[CEW-2 -: 8]};
                    end else begin
                        emit  = 1'b0;
                        n_cur = child_sel[NW-1:0];
                    end
                end
                OP_CLEAR: begin
                    n_ready    = 1'b0;
                    n_error    = 1'b0;
                    n_sp       = '0;
                    n_nodes    = '0;
                    n_cur      = '0;
                    n_top_idx  = '0;
                    n_top_done = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign n_lfwd_hit = lt_we  && (r_top_idx == n_cur);
    assign n_rfwd_hit = rt_we  && (r_top_idx == n_cur);
    assign n_sfwd_hit = stk_we && (stk_waddr == stk_raddr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ready     <= 1'b0;
            r_error     <= 1'b0;
            r_sp        <= '0;
            r_nodes     <= '0;
            r_cur       <= '0;
            r_top_idx   <= '0;
            r_top_done  <= 1'b0;
            r_lfwd_hit  <= 1'b0;
            r_rfwd_hit  <= 1'b0;
            r_sfwd_hit  <= 1'b0;
        end else begin
            if (in_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_ready    <= n_ready;
            r_error    <= n_error;
            r_sp       <= n_sp;
            r_nodes    <= n_nodes;
            r_cur      <= n_cur;
            r_top_idx  <= n_top_idx;
            r_top_done <= n_top_done;
            r_lfwd_hit <= n_lfwd_hit;
            r_rfwd_hit <= n_rfwd_hit;
            r_sfwd_hit <= n_sfwd_hit;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_cfwd_data <= child_wdata;
        r_sfwd_data <= r_top_idx;
    end

    // Left-child entries, indexed by parent node
    hufd_ram #(
        .WIDTH (CEW),
        .DEPTH (NODE_SLOTS)
    ) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (lt_we),
        .i_waddr (r_top_idx),
        .i_wdata (child_wdata),
        .i_raddr (n_cur),
        .o_rdata (lt_q)
    );

    // Right-child entries, indexed by parent node
    hufd_ram #(
        .WIDTH (CEW),
        .DEPTH (NODE_SLOTS)
    ) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (rt_we),
        .i_waddr (r_top_idx),
        .i_wdata (child_wdata),
        .i_raddr (n_cur),
        .o_rdata (rt_q)
    );

    // Open-node stack below the top entry; every entry here has its left child done
    hufd_ram #(
        .WIDTH (NW),
        .DEPTH (STACK_SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_top_idx),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

endmodule
